[design/ast_pkg.sv]
// Shared types, codes and character classes for the assembly source tokenizer.
package ast_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_NUMBER  = 2'd1,
      MODE_SYMBOL  = 2'd2,
      MODE_COMMENT = 2'd3
   } scan_mode_type;

   typedef enum logic [2:0] {
      KIND_HASH    = 3'd0,
      KIND_DOLLAR  = 3'd1,
      KIND_COLON   = 3'd2,
      KIND_INT     = 3'd3,
      KIND_SYMBOL  = 3'd4,
      KIND_ILLEGAL = 3'd5,
      KIND_EOF     = 3'd6
   } token_kind_type;

   localparam logic [7:0] CHAR_EOT   = 8'h00;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int QCNT_BITS   = 3;

   typedef struct packed {
      token_kind_type kind;
      logic [15:0]    start;
      logic [15:0]    length;
      logic [7:0]     single_byte;
   } token_type;

   // One queue entry: every token caused by one byte (one or two).
   typedef struct packed {
      logic      two;
      token_type tok0;
      token_type tok1;
   } record_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

endpackage

[design/ast_channels.sv]
// Handshake channels: source bytes in, tokens out.
interface ast_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

interface ast_token_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic [7:0]  single_byte;
   logic        last;
   modport source (output valid, output token_kind, output token_start,
                   output token_length, output single_byte, output last, input ready);
   modport sink   (input valid, input token_kind, input token_start,
                   input token_length, input single_byte, input last, output ready);
endinterface

[design/assembly_source_tokenizer_unit.sv]
// Each byte's record is written into the queue, and each of its tokens then goes through
// the output register. One byte per cycle on req_if while the queue has room; one token
// per cycle on rsp_if while ready, so a byte that ends a run and emits a second token
// holds the output for both; a four-record queue between the ends absorbs those bursts.
// Reset (synchronous, active high): scan mode idle, offsets zero, queue and output empty.
module assembly_source_tokenizer_unit import ast_pkg::*; #(
   parameter int OFFSET_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   ast_byte_if.sink    req_if,
   ast_token_if.source rsp_if
);

   // front end -> queue
   logic       push;
   record_type push_rec;
   logic       q_full;

   // queue -> back end
   logic       pop;
   logic       q_empty;
   record_type head;

   token_type  out_tok;

   // Mode machine: one byte per cycle while the queue has room.
   ast_front #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_ready (req_if.ready),
      .in_char  (req_if.character),
      .q_full   (q_full),
      .push     (push),
      .push_rec (push_rec)
   );

   // Records of one or two tokens, one per byte that emits anything.
   ast_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .full     (q_full),
      .pop      (pop),
      .empty    (q_empty),
      .head     (head)
   );

   // Splits records into single items; last marks a record's final token.
   ast_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_tok   (out_tok),
      .out_last  (rsp_if.last)
   );

   assign rsp_if.token_kind   = out_tok.kind;
   assign rsp_if.token_start  = out_tok.start;
   assign rsp_if.token_length = out_tok.length;
   assign rsp_if.single_byte  = out_tok.single_byte;

endmodule

[design/ast_front.sv]
// Front end: scan mode machine, classifies each byte and builds token records.
module ast_front import ast_pkg::*; #(
   parameter int OFFSET_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_char,
   input  logic       q_full,
   output logic       push,
   output record_type push_rec
);

   localparam int EXT_BITS = (OFFSET_BITS > 16) ? OFFSET_BITS : 17;

   scan_mode_type          mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [OFFSET_BITS-1:0] run_ff, run_in;

   logic           accept;
   logic           run_hit, idle_go, idle_hit, adv, eof;
   token_kind_type run_kind, idle_kind;
   logic [15:0]    idle_len;
   logic [7:0]     idle_byte;
   token_type      run_tok, idle_tok;

   function automatic logic [15:0] sat16(input logic [OFFSET_BITS-1:0] v);
      logic [EXT_BITS-1:0] x;
      x = EXT_BITS'(v);
      return (x > EXT_BITS'(17'h0FFFF)) ? 16'hFFFF : x[15:0];
   endfunction

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      mode_in   = mode_ff;
      offset_in = offset_ff;
      run_in    = run_ff;
      run_hit   = 1'b0;
      run_kind  = KIND_INT;
      idle_go   = 1'b0;
      idle_hit  = 1'b0;
      idle_kind = KIND_ILLEGAL;
      idle_len  = 16'd1;
      idle_byte = in_char;
      adv       = 1'b0;
      eof       = 1'b0;

      case (mode_ff)
         MODE_NUMBER: begin
            if (is_digit(in_char)) begin
               adv = 1'b1;
            end else begin
               run_hit = 1'b1;
               idle_go = 1'b1;
            end
         end
         MODE_SYMBOL: begin
            if (is_letter(in_char) || is_digit(in_char) || in_char == CHAR_UNDER) begin
               adv = 1'b1;
            end else begin
               run_hit  = 1'b1;
               run_kind = KIND_SYMBOL;
               idle_go  = 1'b1;
            end
         end
         MODE_COMMENT: begin
            if (in_char == CHAR_LF) begin
               mode_in = MODE_IDLE;
               adv     = 1'b1;
            end else if (in_char != CHAR_EOT) begin
               adv = 1'b1;
            end else begin
               idle_go = 1'b1;
            end
         end
         default: begin
            idle_go = 1'b1;
         end
      endcase

      if (idle_go) begin
         mode_in = MODE_IDLE;
         if (in_char == CHAR_EOT) begin
            idle_hit  = 1'b1;
            idle_kind = KIND_EOF;
            idle_len  = 16'd0;
            idle_byte = 8'd0;
            eof       = 1'b1;
         end else if (in_char == CHAR_SPACE || in_char == CHAR_TAB ||
                      in_char == CHAR_CR || in_char == CHAR_LF) begin
            adv = 1'b1;
         end else if (in_char == CHAR_HASH) begin
            idle_hit  = 1'b1;
            idle_kind = KIND_HASH;
            adv       = 1'b1;
         end else if (in_char == CHAR_DOLLAR) begin
            idle_hit  = 1'b1;
            idle_kind = KIND_DOLLAR;
            adv       = 1'b1;
         end else if (in_char == CHAR_COLON) begin
            idle_hit  = 1'b1;
            idle_kind = KIND_COLON;
            adv       = 1'b1;
         end else if (in_char == CHAR_SEMI) begin
            mode_in = MODE_COMMENT;
            adv     = 1'b1;
         end else if (is_digit(in_char)) begin
            mode_in = MODE_NUMBER;
            run_in  = offset_ff;
            adv     = 1'b1;
         end else if (is_letter(in_char)) begin
            mode_in = MODE_SYMBOL;
            run_in  = offset_ff;
            adv     = 1'b1;
         end else begin
            idle_hit = 1'b1;
            adv      = 1'b1;
         end
      end

      if (eof) begin
         offset_in = '0;
         run_in    = '0;
      end else if (adv && offset_ff != {OFFSET_BITS{1'b1}}) begin
         offset_in = offset_ff + 1'b1;
      end
   end

   always_comb begin
      run_tok.kind        = run_kind;
      run_tok.start       = sat16(run_ff);
      run_tok.length      = sat16(offset_ff - run_ff);
      run_tok.single_byte = 8'd0;

      idle_tok.kind        = idle_kind;
      idle_tok.start       = sat16(offset_ff);
      idle_tok.length      = idle_len;
      idle_tok.single_byte = idle_byte;

      push_rec.two  = run_hit && idle_hit;
      push_rec.tok0 = run_hit ? run_tok : idle_tok;
      push_rec.tok1 = idle_tok;
      push          = accept && (run_hit || idle_hit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         offset_ff <= '0;
         run_ff    <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         offset_ff <= offset_in;
         run_ff    <= run_in;
      end
   end

endmodule

[design/ast_queue.sv]
// Short record queue between front end and back end.
module ast_queue import ast_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  record_type push_rec,
   output logic       full,
   input  logic       pop,
   output logic       empty,
   output record_type head
);

   record_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ff, wr_in;
   logic [QPTR_BITS-1:0]   rd_ff, rd_in;
   logic [QCNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign full    = (cnt_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = entry_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_rec;
      end
   end

endmodule

[design/ast_back.sv]
// Back end: unpacks records into single tokens behind an output register.
module ast_back import ast_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  record_type head,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output token_type  out_tok,
   output logic       out_last
);

   logic      valid_ff, valid_in;
   token_type tok_ff, tok_in;
   logic      last_ff, last_in;
   logic      sel_ff, sel_in;
   logic      load, take, fin;

   always_comb begin
      load     = !valid_ff || out_ready;
      take     = load && !q_empty;
      fin      = sel_ff || !head.two;
      pop      = take && fin;
      tok_in   = sel_ff ? head.tok1 : head.tok0;
      last_in  = fin;
      sel_in   = take ? !fin : sel_ff;
      valid_in = take ? 1'b1 : (load ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tok_ff  <= tok_in;
         last_ff <= last_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;
   assign out_last  = last_ff;

endmodule

[design/ast_checker.sv]
// Port-level checks for the tokenizer, bound to the top level.
module ast_checker import ast_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  token_kind,
   input logic [15:0] token_length,
   input logic [7:0]  single_byte,
   input logic        last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(token_kind) &&
         $stable(token_length) && $stable(single_byte) && $stable(last))
      else $error("token changed while stalled");

   a_eof: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && token_kind == KIND_EOF |-> last && token_length == 16'd0 &&
         single_byte == 8'd0)
      else $error("bad end of text token");

   // run tokens (numbers and symbols) carry a single byte of zero
   a_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (token_kind == KIND_INT || token_kind == KIND_SYMBOL) |->
         single_byte == 8'd0)
      else $error("bad run token");

   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (token_kind == KIND_HASH || token_kind == KIND_DOLLAR ||
         token_kind == KIND_COLON || token_kind == KIND_ILLEGAL) |->
         token_length == 16'd1 && last && single_byte != 8'd0)
      else $error("bad one-byte token");

endmodule

bind assembly_source_tokenizer_unit ast_checker u_ast_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .token_kind   (rsp_if.token_kind),
   .token_length (rsp_if.token_length),
   .single_byte  (rsp_if.single_byte),
   .last         (rsp_if.last)
);
